// ===== design/stk_pkg.sv =====
// Shared types and constants for the sorted top-k table.
`timescale 1ns / 1ps

package stk_pkg;

   localparam int CMP_W = 8;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      RD_LAST = 2'd0,
      RD_PREV = 2'd1,
      RD_IDX  = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_STEP,
      ST_LAST_CMP,
      ST_SHIFT_CMP,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_new;
      logic       take_read;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic j_zero;
      logic lower;
   } stat_type;

endpackage

// ===== design/sorted_top_k_table.sv =====
// Top level of the sorted top-k table.
//
//   channel  dir  payload
//   req_     in   tuser: kind; tdata: new_score, new_tag, entry_index
//   rsp_     out  tdata: entry_score, entry_tag, entry_valid, inserted,
//                 insert_position, entries_held
//
// One item at a time: a new item is taken only after the result of the last is taken.
// An insert walks the entry memory from the end toward the front, reading each entry
// in turn and moving it back one place while it scores below the new one.
// Reset empties the table; no clearing pass. A stalled result holds the block.
`timescale 1ns / 1ps

module sorted_top_k_table
   import stk_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // new_score[31:0], new_tag[63:32], entry_index[66:64]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // entry_score[31:0], entry_tag[63:32], entry_valid[64],
                                    // inserted[65], insert_position[68:66],
                                    // entries_held[72:69]
);

   cmd_type  cmd;
   stat_type stat;

   stk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   stk_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== design/stk_ctrl.sv =====
// Controller state machine for the sorted top-k table.
`timescale 1ns / 1ps

module stk_ctrl
   import stk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_PREV;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (kind_type'(req_tuser))
                  KIND_INSERT: begin
                     if (stat.full) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_LAST;
                        state_in   = ST_LAST_CMP;
                     end else begin
                        state_in = ST_INS_STEP;
                     end
                  end
                  KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESP;
                  end
                  KIND_READ: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX;
                     state_in   = ST_RD_WAIT;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_STEP: begin
            if (stat.j_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = ST_SHIFT_CMP;
            end
         end
         ST_LAST_CMP: begin
            // full table: only a score above the last entry gets in
            state_in = stat.lower ? ST_INS_STEP : ST_RESP;
         end
         ST_SHIFT_CMP: begin
            if (stat.lower) begin
               cmd.wr_shift = 1'b1;
               state_in     = ST_INS_STEP;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_RD_WAIT: begin
            cmd.take_read = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/stk_datapath.sv =====
// Datapath for the sorted top-k table: entry memory, count, walk pointer, result.
`timescale 1ns / 1ps

module stk_datapath
   import stk_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [71:0] req_tdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [79:0] rsp_tdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [63:0]   mem [TABLE_DEPTH];
   logic [63:0]   rdata_ff;
   logic [AW-1:0] raddr;
   logic [AW-1:0] j_ff, j_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0]   score_ff, tag_ff;
   logic [2:0]    idx_ff;
   logic [31:0]   res_score_ff, res_tag_ff;
   logic          res_valid_ff, res_ins_ff;
   logic [2:0]    res_pos_ff;
   logic          wr_en;
   logic [63:0]   wdata;
   logic          idx_ok;

   assign stat.full   = (fill_ff == CW'(TABLE_DEPTH));
   assign stat.j_zero = (j_ff == '0);
   assign stat.lower  = (rdata_ff[63:32] < score_ff);

   assign idx_ok = (CMP_W'(idx_ff) < CMP_W'(fill_ff)) &&
                   (CMP_W'(idx_ff) < CMP_W'(TABLE_DEPTH));

   always_comb begin
      case (cmd.rd_sel)
         RD_LAST: raddr = AW'(TABLE_DEPTH - 1);
         RD_IDX:  raddr = AW'(req_tdata[66:64]);
         default: raddr = j_ff - AW'(1);
      endcase
   end

   assign wr_en = cmd.wr_shift | cmd.wr_new;
   assign wdata = cmd.wr_shift ? rdata_ff : {score_ff, tag_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[j_ff] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      j_in = j_ff;
      if (cmd.load) begin
         j_in = stat.full ? AW'(TABLE_DEPTH - 1) : AW'(fill_ff);
      end else if (cmd.wr_shift) begin
         j_in = j_ff - AW'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.wr_new && !stat.full) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      if (cmd.load) begin
         score_ff     <= req_tdata[31:0];
         tag_ff       <= req_tdata[63:32];
         idx_ff       <= req_tdata[66:64];
         res_score_ff <= '0;
         res_tag_ff   <= '0;
         res_valid_ff <= 1'b0;
         res_ins_ff   <= 1'b0;
         res_pos_ff   <= '0;
      end
      if (cmd.take_read && idx_ok) begin
         res_score_ff <= rdata_ff[63:32];
         res_tag_ff   <= rdata_ff[31:0];
         res_valid_ff <= 1'b1;
      end
      if (cmd.wr_new) begin
         res_ins_ff <= 1'b1;
         res_pos_ff <= 3'(j_ff);
      end
   end

   assign rsp_tdata = {7'd0, 4'(fill_ff), res_pos_ff, res_ins_ff, res_valid_ff,
                       res_tag_ff, res_score_ff};

endmodule

// ===== design/stk_checker.sv =====
// Port-level assertions for the sorted top-k table, bound to the top level.
`timescale 1ns / 1ps

module stk_checker #(
   parameter int TABLE_DEPTH = 8
)
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("new item taken while a result is pending");

   a_read_not_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> !rsp_tdata[65])
      else $error("result flags both read and insert");

   a_insert_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] && (TABLE_DEPTH <= 8) |->
         rsp_tdata[68:66] < rsp_tdata[72:69])
      else $error("insert position not below entry count");

   a_req_after_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block ready again right after taking an item");

endmodule

bind sorted_top_k_table stk_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_stk_checker (.*);

// ===== tb/sorted_top_k_table_checker.sv =====
// Checker for the sorted top-k table: predicts every result and compares it.
`timescale 1ns / 1ps

module sorted_top_k_table_checker
   import stk_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   output int          error_count,
   output int          outstanding
);

   // same bit order as rsp_tdata[72:0]
   typedef struct packed {
      logic [3:0]  held;
      logic [2:0]  pos;
      logic        ins;
      logic        valid;
      logic [31:0] tag;
      logic [31:0] score;
   } table_reply;

   logic [31:0] score_tab [DEPTH];
   logic [31:0] tag_tab   [DEPTH];
   int          held;
   table_reply  replies_due [$];

   initial begin
      error_count = 0;
      outstanding = 0;
      held = 0;
   end

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Applies one item to the shadow table and returns the result it causes.
   function automatic table_reply apply_item(kind_type kind, logic [31:0] score,
                                             logic [31:0] tag, logic [2:0] idx);
      table_reply r;
      int         slot;
      int         last;
      r = '0;
      case (kind)
         KIND_INSERT: begin
            slot = 0;
            while (slot < held && score_tab[slot] >= score)
               slot++;
            if (slot < DEPTH) begin
               last = (held < DEPTH) ? held : DEPTH - 1;
               for (int j = last; j > slot; j--) begin
                  score_tab[j] = score_tab[j - 1];
                  tag_tab[j] = tag_tab[j - 1];
               end
               score_tab[slot] = score;
               tag_tab[slot] = tag;
               if (held < DEPTH)
                  held++;
               r.ins = 1'b1;
               r.pos = slot[2:0];
            end
         end
         KIND_CLEAR: begin
            held = 0;
         end
         KIND_READ: begin
            if (idx < held) begin
               r.score = score_tab[idx];
               r.tag = tag_tab[idx];
               r.valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.held = held[3:0];
      return r;
   endfunction

   task automatic check_reply(input table_reply got);
      table_reply want;
      if (replies_due.size() == 0) begin
         report($sformatf("result %h with nothing pending", got));
         return;
      end
      want = replies_due.pop_front();
      check_field("entry_score", got.score, want.score);
      check_field("entry_tag", got.tag, want.tag);
      check_field("entry_valid", got.valid, want.valid);
      check_field("inserted", got.ins, want.ins);
      check_field("insert_position", got.pos, want.pos);
      check_field("entries_held", got.held, want.held);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held = 0;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_reply(rsp_tdata[72:0]);
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_item(kind_type'(req_tuser), req_tdata[31:0],
                                             req_tdata[63:32], req_tdata[66:64]));
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== tb/sorted_top_k_table_tb.sv =====
// Testbench top for the sorted top-k table: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module sorted_top_k_table_tb;
   import stk_pkg::*;

   localparam int DEPTH = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 525;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   int          errors;
   int          outstanding;
   int          idle_cycles;
   bit          steady;

   sorted_top_k_table #(.TABLE_DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   sorted_top_k_table_checker #(.DEPTH(DEPTH)) table_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .error_count(errors),
      .outstanding(outstanding)
   );

   always #4 clock = ~clock;

   function automatic int draw_pause();
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [31:0] score,
                            input logic [31:0] tag, input logic [2:0] idx);
      int pause;
      pause = draw_pause();
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tuser <= kind;
      req_tdata <= {5'b0, idx, tag, score};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // result side backpressure
   initial begin : receiver
      int pause;
      wait (!reset);
      @(negedge clock);
      forever begin
         pause = draw_pause();
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          sent;
      int          mode;
      int          roll;
      logic [31:0] score;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      steady = 1'b0;
      idle_cycles = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, unused kind, ties, fill, full-table drops and rejects
      send_item(KIND_READ, $urandom(), $urandom(), 3'd0);
      send_item(KIND_READ, $urandom(), $urandom(), 3'd7);
      send_item(KIND_UNUSED, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
      send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
      send_item(KIND_INSERT, 32'h0, 32'h0, 3'd7);
      send_item(KIND_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 3'd0);
      send_item(KIND_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 3'd0);
      send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0002, 3'd0);
      send_item(KIND_INSERT, 32'd5, $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'd7, $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'd3, $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'h0, $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'd1, $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'hFFFF_FFFF, $urandom(), 3'd0);
      for (int i = 0; i < DEPTH; i++)
         send_item(KIND_READ, $urandom(), $urandom(), 3'(i));
      send_item(KIND_CLEAR, $urandom(), $urandom(), 3'd0);
      send_item(KIND_READ, $urandom(), $urandom(), 3'd0);
      send_item(KIND_INSERT, 32'h0, $urandom(), 3'd0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 2);
         for (int k = 0; k < 50 && sent < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               0: score = $urandom_range(0, 15);
               1: score = $urandom();
               default: score = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            endcase
            if (roll < 45) begin
               send_item(KIND_INSERT, score, $urandom(), 3'($urandom_range(0, 7)));
            end else if (roll < 94) begin
               send_item(KIND_READ, score, $urandom(), 3'($urandom_range(0, 7)));
            end else if (roll < 96) begin
               send_item(KIND_CLEAR, score, $urandom(), 3'($urandom_range(0, 7)));
            end else begin
               send_item(KIND_UNUSED, score, $urandom(), 3'($urandom_range(0, 7)));
            end
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0)
         @(negedge clock);
      repeat (2 * DEPTH + 8) @(negedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
